[src/dss_pkg.sv]
// shared types, widths and constants of the damped spring smoother
`default_nettype none

package dss_pkg;

  // port field widths
  localparam int TARGET_W   = 32;
  localparam int DT_W       = 16;
  localparam int POS_W      = 32;
  localparam int FREQ_W     = 16;
  localparam int DAMP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // internal value widths
  localparam int OMEGA_W = 27;
  localparam int INNER_W = 27;
  localparam int DENOM_W = 55;
  localparam int SCALE_W = 31;
  localparam int K_W     = 38;
  localparam int TERM_W  = 56;

  // shared multiplier
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = 64;
  localparam int MUL_ACC_W = 96;

  localparam logic [MUL_B_W-1:0] TWO_PI_Q16 = 32'd411775;

  localparam logic [FREQ_W-1:0] FREQ_RST = 16'd256;
  localparam logic [DAMP_W-1:0] DAMP_RST = 16'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 2'd3;

  typedef enum logic [1:0] {
    SH_0,
    SH_8,
    SH_16,
    SH_30
  } dss_shift_t;

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_HI,
    MP_TOP
  } dss_mul_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OMEGA,
    ST_WDT,
    ST_DENOM,
    ST_DIV,
    ST_K,
    ST_TERM,
    ST_VEL,
    ST_STEP,
    ST_DONE
  } dss_state_t;

  typedef struct packed {
    logic                 start;
    logic [MUL_A_W-1:0]   a;
    logic [MUL_B_W-1:0]   b;
    dss_shift_t           sh;
  } dss_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } dss_mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DENOM_W-1:0] denom;
  } dss_div_req_t;

  typedef struct packed {
    logic               done;
    logic [SCALE_W-1:0] quot;
  } dss_div_rsp_t;

endpackage

`default_nettype wire

[src/dss_if.sv]
// stream interfaces of the smoother: input items and result items
`default_nettype none

interface dss_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dss_pkg::TARGET_W-1:0] target;
  logic        [dss_pkg::DT_W-1:0]     time_step;

  modport source (output valid, output target, output time_step, input ready);
  modport sink   (input valid, input target, input time_step, output ready);
endinterface

interface dss_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dss_pkg::POS_W-1:0] position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

`default_nettype wire

[src/dss_mul.sv]
// shared 64x32 multiplier: two 32x32 partial products, rounding right shift
`default_nettype none

module dss_mul (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dss_pkg::dss_mul_req_t req,
  output dss_pkg::dss_mul_rsp_t      rsp
);

  dss_pkg::dss_mul_phase_t phase_r, phase_nxt;
  logic                    done_r, done_nxt;

  logic [dss_pkg::MUL_B_W-1:0]   a_hi_r, a_hi_nxt;
  logic [dss_pkg::MUL_B_W-1:0]   b_r, b_nxt;
  dss_pkg::dss_shift_t           sh_r, sh_nxt;
  logic [dss_pkg::MUL_P_W-1:0]   p_r, p_nxt;
  logic [dss_pkg::MUL_ACC_W-1:0] acc_r, acc_nxt;
  logic [dss_pkg::MUL_ACC_W-1:0] half;

  // rounding constant preloaded into the accumulator
  always_comb begin
    case (req.sh)
      dss_pkg::SH_0:  half = '0;
      dss_pkg::SH_8:  half = dss_pkg::MUL_ACC_W'(1) << 7;
      dss_pkg::SH_16: half = dss_pkg::MUL_ACC_W'(1) << 15;
      dss_pkg::SH_30: half = dss_pkg::MUL_ACC_W'(1) << 29;
      default:        half = '0;
    endcase
  end

  always_comb begin
    phase_nxt = dss_pkg::MP_IDLE;
    done_nxt  = 1'b0;
    a_hi_nxt  = a_hi_r;
    b_nxt     = b_r;
    sh_nxt    = sh_r;
    p_nxt     = p_r;
    acc_nxt   = acc_r;
    if (req.start) begin
      phase_nxt = dss_pkg::MP_HI;
      a_hi_nxt  = req.a[dss_pkg::MUL_A_W-1:dss_pkg::MUL_B_W];
      b_nxt     = req.b;
      sh_nxt    = req.sh;
      p_nxt     = dss_pkg::MUL_P_W'(req.a[dss_pkg::MUL_B_W-1:0]) *
                  dss_pkg::MUL_P_W'(req.b);
      acc_nxt   = half;
    end else begin
      case (phase_r)
        dss_pkg::MP_HI: begin
          phase_nxt = dss_pkg::MP_TOP;
          acc_nxt   = acc_r + dss_pkg::MUL_ACC_W'(p_r);
          p_nxt     = dss_pkg::MUL_P_W'(a_hi_r) * dss_pkg::MUL_P_W'(b_r);
        end
        dss_pkg::MP_TOP: begin
          done_nxt = 1'b1;
          acc_nxt  = acc_r + {p_r, {dss_pkg::MUL_B_W{1'b0}}};
        end
        default: begin
          phase_nxt = dss_pkg::MP_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dss_pkg::MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_hi_r <= a_hi_nxt;
    b_r    <= b_nxt;
    sh_r   <= sh_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    case (sh_r)
      dss_pkg::SH_0:  rsp.prod = acc_r[63:0];
      dss_pkg::SH_8:  rsp.prod = acc_r[71:8];
      dss_pkg::SH_16: rsp.prod = acc_r[79:16];
      dss_pkg::SH_30: rsp.prod = acc_r[93:30];
      default:        rsp.prod = acc_r[63:0];
    endcase
  end

endmodule

`default_nettype wire

[src/dss_div.sv]
// restoring divider: scale = round(2^62 / denom), one quotient bit per cycle
`default_nettype none

module dss_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dss_pkg::dss_div_req_t req,
  output dss_pkg::dss_div_rsp_t      rsp
);

  localparam int STEPS = dss_pkg::SCALE_W;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int NUM_W = 63;
  localparam int REM_W = dss_pkg::DENOM_W + 1;

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [STEPS-1:0]            n_r, n_nxt;
  logic [STEPS-1:0]            q_r, q_nxt;
  logic [dss_pkg::DENOM_W-1:0] den_r, den_nxt;

  logic [NUM_W-1:0] num;
  logic [REM_W-1:0] trial;
  logic             fits;

  // dividend with the rounding half folded in
  assign num   = (NUM_W'(1) << 62) + NUM_W'(req.denom >> 1);
  assign trial = {rem_r[REM_W-2:0], n_r[STEPS-1]};
  assign fits  = trial >= REM_W'(den_r);

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    n_nxt    = n_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      rem_nxt  = REM_W'(num[NUM_W-1:STEPS]);
      n_nxt    = num[STEPS-1:0];
      q_nxt    = '0;
      den_nxt  = req.denom;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - REM_W'(den_r)) : trial;
      q_nxt   = {q_r[STEPS-2:0], fits};
      n_nxt   = {n_r[STEPS-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    n_r   <= n_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule

`default_nettype wire

[src/damped_spring_smoother.sv]
// top level: sequencer of the damped spring smoother around the shared units
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        target (s32 Q16.16), time_step (u16 Q0.16)
//  out_ch   out  valid/ready        position (s32 Q16.16)
//  cfg      in   cfg_we, no ready   cfg_index (2b), cfg_wdata (32b)
//
// one input beat runs seven products on the shared multiplier and one pass of
// the restoring divider between accept and result
// in_ch.ready is high only while the sequencer is idle; a result waiting in
// the output register does not block the next input beat, the sequencer only
// holds in its last state if the previous result has not been taken yet
// reset (synchronous, active low) loads the register defaults and clears
// position, velocity and the primed flag
`default_nettype none

module damped_spring_smoother (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [dss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  dss_in_if.sink                                in_ch,
  dss_out_if.source                             out_ch
);

  localparam logic signed [dss_pkg::TERM_W-1:0] SAT_HI = 56'sd2147483647;
  localparam logic signed [dss_pkg::TERM_W-1:0] SAT_LO = -56'sd2147483648;

  function automatic logic signed [dss_pkg::POS_W-1:0] sat_pos(
    input logic signed [dss_pkg::TERM_W-1:0] v
  );
    logic signed [dss_pkg::POS_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh80000000;
    end else begin
      r = v[dss_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  // sequencer control
  dss_pkg::dss_state_t state_r, state_nxt;
  logic                issued_r, issued_nxt;
  logic                primed_r, primed_nxt;
  logic                out_valid_r, out_valid_nxt;

  // configuration registers
  logic        [dss_pkg::FREQ_W-1:0] freq_r, freq_nxt;
  logic        [dss_pkg::DAMP_W-1:0] damp_r, damp_nxt;
  logic                              use_start_r, use_start_nxt;
  logic signed [dss_pkg::POS_W-1:0]  start_pos_r, start_pos_nxt;

  // spring state
  logic signed [dss_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic signed [dss_pkg::POS_W-1:0] vel_r, vel_nxt;

  // per-item working values
  logic signed [dss_pkg::TARGET_W-1:0] tgt_r, tgt_nxt;
  logic        [dss_pkg::DT_W-1:0]     dt_r, dt_nxt;
  logic        [dss_pkg::OMEGA_W-1:0]  omega_r, omega_nxt;
  logic        [dss_pkg::OMEGA_W-1:0]  wdt_r, wdt_nxt;
  logic        [dss_pkg::DENOM_W-1:0]  denom_r, denom_nxt;
  logic        [dss_pkg::SCALE_W-1:0]  scale_r, scale_nxt;
  logic        [dss_pkg::K_W-1:0]      k_r, k_nxt;
  logic signed [dss_pkg::TERM_W-1:0]   term_r, term_nxt;
  logic signed [dss_pkg::POS_W-1:0]    out_pos_r, out_pos_nxt;

  // shared units
  dss_pkg::dss_mul_req_t mul_req;
  dss_pkg::dss_mul_rsp_t mul_rsp;
  dss_pkg::dss_div_req_t div_req;
  dss_pkg::dss_div_rsp_t div_rsp;

  // derived operands
  logic signed [dss_pkg::POS_W:0]      diff;
  logic                                diff_neg;
  logic        [dss_pkg::POS_W-1:0]    diff_mag;
  logic signed [dss_pkg::TERM_W-1:0]   acc;
  logic                                acc_neg;
  logic        [dss_pkg::TERM_W-1:0]   acc_mag;
  logic                                vel_neg;
  logic        [dss_pkg::POS_W-1:0]    vel_mag;
  logic        [dss_pkg::INNER_W-1:0]  inner;
  logic        [dss_pkg::TERM_W-1:0]   prod_lo;
  logic signed [dss_pkg::TERM_W-1:0]   vel_wide;
  logic        [dss_pkg::POS_W:0]      step_mag;
  logic signed [dss_pkg::POS_W+1:0]    step;
  logic signed [dss_pkg::POS_W+1:0]    pos_sum;

  dss_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  dss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // position error, needs the 33-bit signed range
  assign diff     = {pos_r[dss_pkg::POS_W-1], pos_r} - {tgt_r[dss_pkg::TARGET_W-1], tgt_r};
  assign diff_neg = diff[dss_pkg::POS_W];
  assign diff_mag = diff_neg ? dss_pkg::POS_W'(-diff) : diff[dss_pkg::POS_W-1:0];

  // velocity minus spring pull, before scaling
  assign acc     = dss_pkg::TERM_W'(vel_r) - term_r;
  assign acc_neg = acc[dss_pkg::TERM_W-1];
  assign acc_mag = acc_neg ? dss_pkg::TERM_W'(-acc) : dss_pkg::TERM_W'(acc);

  assign vel_neg = vel_r[dss_pkg::POS_W-1];
  assign vel_mag = vel_neg ? dss_pkg::POS_W'(-vel_r) : dss_pkg::POS_W'(vel_r);

  // 2*damping + wdt, damping is Q4.12 so the doubling lands at shift 5
  assign inner = dss_pkg::INNER_W'({damp_r, 5'b0}) + wdt_r;

  assign prod_lo  = mul_rsp.prod[dss_pkg::TERM_W-1:0];
  assign vel_wide = acc_neg ? dss_pkg::TERM_W'(-prod_lo) : dss_pkg::TERM_W'(prod_lo);
  assign step_mag = mul_rsp.prod[dss_pkg::POS_W:0];
  assign step     = vel_neg ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
  assign pos_sum  = (dss_pkg::POS_W+2)'(pos_r) + step;

  // operand select for the shared multiplier
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    mul_req.sh    = dss_pkg::SH_0;
    case (state_r)
      dss_pkg::ST_OMEGA: begin
        mul_req.a  = dss_pkg::MUL_A_W'(freq_r);
        mul_req.b  = dss_pkg::TWO_PI_Q16;
        mul_req.sh = dss_pkg::SH_8;
      end
      dss_pkg::ST_WDT: begin
        mul_req.a  = dss_pkg::MUL_A_W'(omega_r);
        mul_req.b  = dss_pkg::MUL_B_W'(dt_r);
        mul_req.sh = dss_pkg::SH_16;
      end
      dss_pkg::ST_DENOM: begin
        mul_req.a  = dss_pkg::MUL_A_W'(wdt_r);
        mul_req.b  = dss_pkg::MUL_B_W'(inner);
        mul_req.sh = dss_pkg::SH_0;
      end
      dss_pkg::ST_K: begin
        mul_req.a  = dss_pkg::MUL_A_W'(wdt_r);
        mul_req.b  = dss_pkg::MUL_B_W'(omega_r);
        mul_req.sh = dss_pkg::SH_16;
      end
      dss_pkg::ST_TERM: begin
        mul_req.a  = dss_pkg::MUL_A_W'(k_r);
        mul_req.b  = diff_mag;
        mul_req.sh = dss_pkg::SH_16;
      end
      dss_pkg::ST_VEL: begin
        mul_req.a  = dss_pkg::MUL_A_W'(acc_mag);
        mul_req.b  = dss_pkg::MUL_B_W'(scale_r);
        mul_req.sh = dss_pkg::SH_30;
      end
      dss_pkg::ST_STEP: begin
        mul_req.a  = dss_pkg::MUL_A_W'(vel_mag);
        mul_req.b  = dss_pkg::MUL_B_W'(dt_r);
        mul_req.sh = dss_pkg::SH_16;
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
    // fire once on entry to every multiply state
    if (state_r != dss_pkg::ST_IDLE && state_r != dss_pkg::ST_DIV &&
        state_r != dss_pkg::ST_DONE && !issued_r) begin
      mul_req.start = 1'b1;
    end
  end

  assign div_req.start = (state_r == dss_pkg::ST_DIV) && !issued_r;
  assign div_req.denom = denom_r;

  // next state and datapath captures
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    primed_nxt    = primed_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    freq_nxt      = freq_r;
    damp_nxt      = damp_r;
    use_start_nxt = use_start_r;
    start_pos_nxt = start_pos_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    tgt_nxt       = tgt_r;
    dt_nxt        = dt_r;
    omega_nxt     = omega_r;
    wdt_nxt       = wdt_r;
    denom_nxt     = denom_r;
    scale_nxt     = scale_r;
    k_nxt         = k_r;
    term_nxt      = term_r;
    out_pos_nxt   = out_pos_r;

    // register writes, only while idle by contract
    if (cfg_we) begin
      case (cfg_index)
        dss_pkg::CFG_FREQUENCY: freq_nxt      = cfg_wdata[dss_pkg::FREQ_W-1:0];
        dss_pkg::CFG_DAMPING:   damp_nxt      = cfg_wdata[dss_pkg::DAMP_W-1:0];
        dss_pkg::CFG_USE_START: use_start_nxt = cfg_wdata[0];
        dss_pkg::CFG_START_POS: start_pos_nxt = cfg_wdata[dss_pkg::POS_W-1:0];
        default:                freq_nxt      = freq_r;
      endcase
    end

    case (state_r)
      dss_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          tgt_nxt    = in_ch.target;
          dt_nxt     = in_ch.time_step;
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_OMEGA;
          // first beat after reset seeds the spring
          if (!primed_r) begin
            pos_nxt    = use_start_r ? start_pos_r : in_ch.target;
            vel_nxt    = '0;
            primed_nxt = 1'b1;
          end
        end
      end
      dss_pkg::ST_OMEGA: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          omega_nxt  = mul_rsp.prod[dss_pkg::OMEGA_W-1:0];
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_WDT;
        end
      end
      dss_pkg::ST_WDT: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          wdt_nxt    = mul_rsp.prod[dss_pkg::OMEGA_W-1:0];
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_DENOM;
        end
      end
      dss_pkg::ST_DENOM: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          denom_nxt  = (dss_pkg::DENOM_W'(1) << 32) + mul_rsp.prod[dss_pkg::DENOM_W-1:0];
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_DIV;
        end
      end
      dss_pkg::ST_DIV: begin
        issued_nxt = 1'b1;
        if (div_rsp.done) begin
          scale_nxt  = div_rsp.quot;
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_K;
        end
      end
      dss_pkg::ST_K: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          k_nxt      = mul_rsp.prod[dss_pkg::K_W-1:0];
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_TERM;
        end
      end
      dss_pkg::ST_TERM: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          term_nxt   = diff_neg ? dss_pkg::TERM_W'(-prod_lo) : dss_pkg::TERM_W'(prod_lo);
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_VEL;
        end
      end
      dss_pkg::ST_VEL: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          vel_nxt    = sat_pos(vel_wide);
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_STEP;
        end
      end
      dss_pkg::ST_STEP: begin
        issued_nxt = 1'b1;
        if (mul_rsp.done) begin
          pos_nxt    = sat_pos(dss_pkg::TERM_W'(pos_sum));
          issued_nxt = 1'b0;
          state_nxt  = dss_pkg::ST_DONE;
        end
      end
      dss_pkg::ST_DONE: begin
        // hand the position over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_pos_nxt   = pos_r;
          out_valid_nxt = 1'b1;
          state_nxt     = dss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt  = dss_pkg::ST_IDLE;
        issued_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dss_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      freq_r      <= dss_pkg::FREQ_RST;
      damp_r      <= dss_pkg::DAMP_RST;
      use_start_r <= 1'b0;
      start_pos_r <= '0;
      pos_r       <= '0;
      vel_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
      freq_r      <= freq_nxt;
      damp_r      <= damp_nxt;
      use_start_r <= use_start_nxt;
      start_pos_r <= start_pos_nxt;
      pos_r       <= pos_nxt;
      vel_r       <= vel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r     <= tgt_nxt;
    dt_r      <= dt_nxt;
    omega_r   <= omega_nxt;
    wdt_r     <= wdt_nxt;
    denom_r   <= denom_nxt;
    scale_r   <= scale_nxt;
    k_r       <= k_nxt;
    term_r    <= term_nxt;
    out_pos_r <= out_pos_nxt;
  end

  assign in_ch.ready     = (state_r == dss_pkg::ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_pos_r;

  // an accepted beat always leaves the spring primed and starts the sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == dss_pkg::ST_OMEGA) && primed_r)
    else $error("accepted beat did not start the sequence");

  // the multiplier only answers a request issued from a multiply state
  a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> issued_r && (state_r != dss_pkg::ST_IDLE) &&
                     (state_r != dss_pkg::ST_DIV) && (state_r != dss_pkg::ST_DONE))
    else $error("multiplier result outside a multiply state");

  // the divider only answers while the sequencer waits on it
  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == dss_pkg::ST_DIV) && issued_r)
    else $error("divider result outside the divide state");

  // a new result is only loaded from the final state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && !out_ch.ready)) |->
      (state_r == dss_pkg::ST_DONE))
    else $error("result loaded outside the final state");

endmodule

`default_nettype wire
